FILE: src/ffa_pkg.sv
// ffa_pkg: shared constants, codes and types of the first-fit free-list allocator
// no dependencies; imported by the top level, ffa_alu, ffa_ctrl and ffa_checker

package ffa_pkg;

	localparam int HEAP_UNITS = 4096;
	localparam int UNIT_BYTES = 16;
	localparam int SLOTS      = HEAP_UNITS + 1;
	localparam int AW         = $clog2(SLOTS);
	localparam int REQ_W      = 16;
	localparam int ADDR_W     = 13;
	localparam int NEED_MAX   = (2 ** REQ_W - 1 + UNIT_BYTES - 1) / UNIT_BYTES + 1;
	localparam int NEED_W     = $clog2(NEED_MAX + 1);
	localparam int OPW        = ((AW > NEED_W) ? AW : NEED_W) + 1;
	localparam int CNT_W      = $clog2(SLOTS + 1);

	typedef enum logic [1:0] {
		ST_ALLOC = 2'd0,
		ST_NOFIT = 2'd1,
		ST_FREED = 2'd2
	} status_t;

	typedef enum logic {
		MODE_ALLOC = 1'b0,
		MODE_FREE  = 1'b1
	} mode_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef enum logic [4:0] {
		S_CLR,
		S_IDLE,
		S_A_ROV,
		S_A_P,
		S_A_RD,
		S_A_CHK,
		S_A_SPL1,
		S_A_SPL2,
		S_F_RD,
		S_F_CHK,
		S_F_SH,
		S_F_SN,
		S_F_M1,
		S_F_M2,
		S_F_P1,
		S_F_P2,
		S_RESP
	} state_t;

	typedef struct packed {
		alu_op_t        op;
		logic [OPW-1:0] a;
		logic [OPW-1:0] b;
		logic [OPW-1:0] c;
	} alu_req_t;

	typedef struct packed {
		logic [OPW-1:0] res;
		logic           eq;
		logic           ge;
	} alu_rsp_t;

	typedef struct packed {
		logic          we_link;
		logic          we_size;
		logic [AW-1:0] waddr;
		logic [AW-1:0] wlink;
		logic [AW-1:0] wsize;
		logic [AW-1:0] raddr;
	} mem_req_t;

endpackage

FILE: src/first_fit_free_list_allocator.sv
// first_fit_free_list_allocator: top level, link and size memories around the sequencer
// depends on ffa_pkg, ffa_ram, ffa_ctrl
//
// channel  direction  handshake          beat fields
// in       input      in_valid/in_stall  mode, request_bytes, block_address
// out      output     out_valid/out_stall status, granted_address
//
// after reset a clearing pass writes all 4097 store entries, one per cycle; in_stall stays high
// an allocation reads the rover's link, then reads and checks entries; a split adds two writes
// a free reads and checks entries, then links the block in, merging it with free neighbours
// an ignored free skips the walk, which reads entries through the registered memory read port
// a result beat waits in the output register; a stalled output holds the next result back

module first_fit_free_list_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic [ffa_pkg::REQ_W-1:0]   request_bytes,
	input  logic [ffa_pkg::ADDR_W-1:0]  block_address,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [ffa_pkg::ADDR_W-1:0]  granted_address
);

	import ffa_pkg::*;

	mem_req_t mreq;
	logic [AW-1:0] link_rd, size_rd;

	ffa_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.mode            (mode),
		.request_bytes   (request_bytes),
		.block_address   (block_address),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.granted_address (granted_address),
		.mreq            (mreq),
		.link_rd         (link_rd),
		.size_rd         (size_rd)
	);

	ffa_ram #(
		.DEPTH (SLOTS),
		.WIDTH (AW)
	) u_link_ram (
		.clk   (clk),
		.we    (mreq.we_link),
		.waddr (mreq.waddr),
		.wdata (mreq.wlink),
		.raddr (mreq.raddr),
		.rdata (link_rd)
	);

	ffa_ram #(
		.DEPTH (SLOTS),
		.WIDTH (AW)
	) u_size_ram (
		.clk   (clk),
		.we    (mreq.we_size),
		.waddr (mreq.waddr),
		.wdata (mreq.wsize),
		.raddr (mreq.raddr),
		.rdata (size_rd)
	);

endmodule

FILE: src/ffa_ram.sv
// ffa_ram: generic single write port, single read port memory with registered read data
// no dependencies

module ffa_ram #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 1
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/ffa_alu.sv
// ffa_alu: shared add/subtract unit with equality and magnitude flags
// depends on ffa_pkg

module ffa_alu (
	input  ffa_pkg::alu_req_t req,
	output ffa_pkg::alu_rsp_t rsp
);

	import ffa_pkg::*;

	logic [OPW-1:0] res;

	assign res     = (req.op == ALU_SUB) ? (req.a - req.b) : (req.a + req.b);
	assign rsp.res = res;
	assign rsp.eq  = (res == req.c);
	assign rsp.ge  = (req.a >= req.b);

endmodule

FILE: src/ffa_ctrl.sv
// ffa_ctrl: sequencer for list walks, splits and merges, plus the result register
// depends on ffa_pkg and ffa_alu

module ffa_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        mode,
	input  logic [ffa_pkg::REQ_W-1:0]   request_bytes,
	input  logic [ffa_pkg::ADDR_W-1:0]  block_address,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [ffa_pkg::ADDR_W-1:0]  granted_address,
	output ffa_pkg::mem_req_t           mreq,
	input  logic [ffa_pkg::AW-1:0]      link_rd,
	input  logic [ffa_pkg::AW-1:0]      size_rd
);

	import ffa_pkg::*;

	localparam logic [OPW:0]   SLOTS_X  = (OPW + 1)'(SLOTS);
	localparam logic [OPW:0]   SLOTS_X2 = (OPW + 1)'(2 * SLOTS);
	localparam logic [AW-1:0]  HEAP_A   = AW'(HEAP_UNITS);
	localparam logic [AW-1:0]  ONE_A    = AW'(1);
	localparam logic [CNT_W-1:0] K_LAST = CNT_W'(SLOTS);
	localparam logic [CNT_W-1:0] K_CLR  = CNT_W'(HEAP_UNITS);

	state_t state_q, state_d;
	logic [CNT_W-1:0] k_q;
	logic [AW-1:0] rover_q, p_q, prev_q, nx_q, h_q, sp_q, sh_q, snx_q, lnx_q, lh_q, nsz_q;
	logic [NEED_W-1:0] need_q, need_d;
	logic mrg_q;
	status_t res_status_q, status_q;
	logic [ADDR_W-1:0] res_addr_q, granted_q;
	logic out_valid_q;

	alu_req_t alu_req;
	alu_rsp_t alu_rsp;
	logic in_acc, addr_bad, found, walk_end, out_load;
	logic [AW-1:0] h_d, fold_p;
	logic [OPW:0] sum_x;

	ffa_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	assign in_stall        = (state_q != S_IDLE);
	assign in_acc          = in_valid && (state_q == S_IDLE);
	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign granted_address = granted_q;
	assign out_load        = (state_q == S_RESP) && (!out_valid_q || !out_stall);

	assign need_d   = NEED_W'((32'(request_bytes) + UNIT_BYTES - 1) / UNIT_BYTES + 1);
	assign addr_bad = (32'(block_address) < 2) || (32'(block_address) > HEAP_UNITS + 1);
	assign h_d      = AW'(32'(block_address) - 1);
	assign walk_end = (k_q == K_LAST);

	assign found = ((h_q > p_q) && (h_q < link_rd)) ||
		((p_q >= link_rd) && ((h_q > p_q) || (h_q < link_rd)));

	// tail header index wraps round the store
	assign sum_x = {1'b0, alu_rsp.res};
	always_comb begin
		if (sum_x >= SLOTS_X2) begin
			fold_p = AW'(sum_x - SLOTS_X2);
		end else if (sum_x >= SLOTS_X) begin
			fold_p = AW'(sum_x - SLOTS_X);
		end else begin
			fold_p = AW'(sum_x);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mreq    = '0;
		alu_req = '{op: ALU_ADD, a: '0, b: '0, c: '0};
		case (state_q)
			S_CLR: begin
				mreq.we_link = 1'b1;
				mreq.we_size = 1'b1;
				mreq.waddr   = k_q[AW-1:0];
				mreq.wlink   = (k_q == CNT_W'(0)) ? ONE_A : '0;
				mreq.wsize   = (k_q == CNT_W'(1)) ? HEAP_A : '0;
				if (k_q == K_CLR) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					if (mode_t'(mode) == MODE_ALLOC) begin
						state_d = S_A_ROV;
					end else if (addr_bad) begin
						state_d = S_RESP;
					end else begin
						state_d = S_F_RD;
					end
				end
			end
			S_A_ROV: begin
				mreq.raddr = rover_q;
				state_d    = S_A_P;
			end
			S_A_P: begin
				state_d = S_A_RD;
			end
			S_A_RD: begin
				mreq.raddr = p_q;
				state_d    = S_A_CHK;
			end
			S_A_CHK: begin
				alu_req = '{op: ALU_SUB, a: OPW'(size_rd), b: OPW'(need_q), c: '0};
				if (alu_rsp.ge) begin
					if (alu_rsp.eq) begin
						mreq.we_link = 1'b1;
						mreq.waddr   = prev_q;
						mreq.wlink   = link_rd;
						state_d      = S_RESP;
					end else begin
						state_d = S_A_SPL1;
					end
				end else if ((p_q == rover_q) || walk_end) begin
					state_d = S_RESP;
				end else begin
					state_d = S_A_RD;
				end
			end
			S_A_SPL1: begin
				mreq.we_size = 1'b1;
				mreq.waddr   = p_q;
				mreq.wsize   = nsz_q;
				alu_req      = '{op: ALU_ADD, a: OPW'(p_q), b: OPW'(nsz_q), c: '0};
				state_d      = S_A_SPL2;
			end
			S_A_SPL2: begin
				mreq.we_size = 1'b1;
				mreq.waddr   = p_q;
				mreq.wsize   = AW'(need_q);
				state_d      = S_RESP;
			end
			S_F_RD: begin
				mreq.raddr = p_q;
				state_d    = S_F_CHK;
			end
			S_F_CHK: begin
				if (found) begin
					state_d = S_F_SH;
				end else if (walk_end) begin
					state_d = S_RESP;
				end else begin
					state_d = S_F_RD;
				end
			end
			S_F_SH: begin
				mreq.raddr = h_q;
				state_d    = S_F_SN;
			end
			S_F_SN: begin
				mreq.raddr = nx_q;
				state_d    = S_F_M1;
			end
			S_F_M1: begin
				alu_req = '{op: ALU_ADD, a: OPW'(h_q), b: OPW'(sh_q), c: OPW'(nx_q)};
				state_d = S_F_M2;
			end
			S_F_M2: begin
				mreq.we_link = 1'b1;
				mreq.waddr   = h_q;
				if (mrg_q) begin
					alu_req      = '{op: ALU_ADD, a: OPW'(sh_q), b: OPW'(snx_q), c: '0};
					mreq.we_size = 1'b1;
					mreq.wsize   = alu_rsp.res[AW-1:0];
					mreq.wlink   = lnx_q;
				end else begin
					mreq.wlink = nx_q;
				end
				state_d = S_F_P1;
			end
			S_F_P1: begin
				alu_req = '{op: ALU_ADD, a: OPW'(p_q), b: OPW'(sp_q), c: OPW'(h_q)};
				state_d = S_F_P2;
			end
			S_F_P2: begin
				mreq.we_link = 1'b1;
				mreq.waddr   = p_q;
				if (mrg_q) begin
					alu_req      = '{op: ALU_ADD, a: OPW'(sp_q), b: OPW'(sh_q), c: '0};
					mreq.we_size = 1'b1;
					mreq.wsize   = alu_rsp.res[AW-1:0];
					mreq.wlink   = lh_q;
				end else begin
					mreq.wlink = h_q;
				end
				state_d = S_RESP;
			end
			S_RESP: begin
				if (!out_valid_q || !out_stall) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			rover_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: begin
					k_q <= k_q + CNT_W'(1);
				end
				S_IDLE: begin
					if (in_acc) begin
						k_q <= '0;
					end
				end
				S_A_CHK: begin
					if (alu_rsp.ge) begin
						if (alu_rsp.eq) begin
							rover_q <= prev_q;
						end
					end else begin
						k_q <= k_q + CNT_W'(1);
					end
				end
				S_A_SPL2: begin
					rover_q <= prev_q;
				end
				S_F_CHK: begin
					k_q <= k_q + CNT_W'(1);
				end
				S_F_P2: begin
					rover_q <= p_q;
				end
				default: begin
				end
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers and result beat
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					need_q       <= need_d;
					prev_q       <= rover_q;
					p_q          <= rover_q;
					h_q          <= h_d;
					res_status_q <= ST_FREED;
					res_addr_q   <= '0;
				end
			end
			S_A_P: begin
				p_q <= link_rd;
			end
			S_A_CHK: begin
				if (alu_rsp.ge) begin
					res_status_q <= ST_ALLOC;
					if (alu_rsp.eq) begin
						res_addr_q <= ADDR_W'(32'(p_q) + 1);
					end else begin
						nsz_q <= alu_rsp.res[AW-1:0];
					end
				end else if ((p_q == rover_q) || walk_end) begin
					res_status_q <= ST_NOFIT;
					res_addr_q   <= '0;
				end else begin
					prev_q <= p_q;
					p_q    <= link_rd;
				end
			end
			S_A_SPL1: begin
				p_q <= fold_p;
			end
			S_A_SPL2: begin
				res_addr_q <= ADDR_W'(32'(p_q) + 1);
			end
			S_F_CHK: begin
				if (found) begin
					nx_q <= link_rd;
					sp_q <= size_rd;
				end else begin
					p_q <= link_rd;
				end
			end
			S_F_SN: begin
				sh_q <= size_rd;
			end
			S_F_M1: begin
				snx_q <= size_rd;
				lnx_q <= link_rd;
				mrg_q <= alu_rsp.eq;
			end
			S_F_M2: begin
				if (mrg_q) begin
					sh_q <= alu_rsp.res[AW-1:0];
					lh_q <= lnx_q;
				end else begin
					lh_q <= nx_q;
				end
			end
			S_F_P1: begin
				mrg_q <= alu_rsp.eq;
			end
			default: begin
			end
		endcase
		if (out_load) begin
			status_q  <= res_status_q;
			granted_q <= res_addr_q;
		end
	end

endmodule

FILE: src/ffa_checker.sv
// ffa_checker: port-level checks on the allocator, bound to the top level
// depends on ffa_pkg and first_fit_free_list_allocator

module ffa_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [1:0]                  status,
	input logic [ffa_pkg::ADDR_W-1:0]  granted_address
);

	import ffa_pkg::*;

	// one request at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while busy");

	a_no_addr_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NOFIT || status == ST_FREED) |-> granted_address == '0)
		else $error("address given without a grant");

	a_grant_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_ALLOC |-> granted_address != '0)
		else $error("grant with null address");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> !$rose(out_valid))
		else $error("result without processing time");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(granted_address))
		else $error("stalled output beat changed");

endmodule

bind first_fit_free_list_allocator ffa_checker u_ffa_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_stall        (in_stall),
	.out_valid       (out_valid),
	.out_stall       (out_stall),
	.status          (status),
	.granted_address (granted_address)
);

FILE: tb/first_fit_free_list_allocator_tb.sv
// first_fit_free_list_allocator_tb: self-checking bench for the first-fit heap allocator
// depends on ffa_pkg and first_fit_free_list_allocator; holds its own heap predictor
// directed whole-heap, ignored-free, split/merge and unchecked-free tests plus random traffic

module first_fit_free_list_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ffa_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int TAIL_CYCLES = 64;
	localparam int LIVE_CAP    = 48;

	typedef struct packed {
		status_t           st;
		logic [ADDR_W-1:0] addr;
	} grant_result_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              mode;
	logic [REQ_W-1:0]  request_bytes;
	logic [ADDR_W-1:0] block_address;
	logic              out_valid;
	logic              out_stall;
	logic [1:0]        status;
	logic [ADDR_W-1:0] granted_address;

	int unsigned heap_link [0:HEAP_UNITS];
	int unsigned heap_size [0:HEAP_UNITS];
	int unsigned rover_idx;

	grant_result_t     pending_grants [$];
	logic [ADDR_W-1:0] live_blocks [$];
	int                send_idle_pct;
	int                stall_pct;
	int                fail_count;
	int                cycle_count;

	first_fit_free_list_allocator dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.mode            (mode),
		.request_bytes   (request_bytes),
		.block_address   (block_address),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.status          (status),
		.granted_address (granted_address)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic void heap_reset();
		for (int i = 0; i <= HEAP_UNITS; i++) begin
			heap_link[i] = 0;
			heap_size[i] = 0;
		end
		heap_link[0] = 1;
		heap_link[1] = 0;
		heap_size[1] = HEAP_UNITS;
		rover_idx = 0;
	endfunction

	function automatic grant_result_t predict_alloc(input logic [REQ_W-1:0] bytes);
		int unsigned need;
		int unsigned prev;
		int unsigned p;
		grant_result_t r;
		need = (32'(bytes) + UNIT_BYTES - 1) / UNIT_BYTES + 1;
		r.st = ST_NOFIT;
		r.addr = '0;
		prev = rover_idx;
		p = heap_link[prev];
		for (int unsigned k = 0; k < SLOTS + 1; k++) begin
			if (heap_size[p] >= need) begin
				if (heap_size[p] == need) begin
					heap_link[prev] = heap_link[p];
				end else begin
					heap_size[p] -= need;
					p = (p + heap_size[p]) % SLOTS;
					heap_size[p] = need;
				end
				rover_idx = prev;
				r.st = ST_ALLOC;
				r.addr = ADDR_W'(p + 1);
				return r;
			end
			if (p == rover_idx)
				return r;
			prev = p;
			p = heap_link[p];
		end
		return r;
	endfunction

	function automatic grant_result_t predict_free(input logic [ADDR_W-1:0] addr);
		int unsigned h;
		int unsigned p;
		int unsigned nx;
		bit found;
		grant_result_t r;
		r.st = ST_FREED;
		r.addr = '0;
		found = 1'b0;
		if (addr < 2 || 32'(addr) - 1 > HEAP_UNITS)
			return r;
		h = 32'(addr) - 1;
		p = rover_idx;
		for (int unsigned k = 0; k < SLOTS + 1; k++) begin
			nx = heap_link[p];
			if (h > p && h < nx) begin
				found = 1'b1;
				break;
			end
			if (p >= nx && (h > p || h < nx)) begin
				found = 1'b1;
				break;
			end
			p = nx;
		end
		if (!found)
			return r;
		nx = heap_link[p];
		if (h + heap_size[h] == nx) begin
			heap_size[h] += heap_size[nx];
			heap_link[h] = heap_link[nx];
		end else begin
			heap_link[h] = nx;
		end
		if (p + heap_size[p] == h) begin
			heap_size[p] += heap_size[h];
			heap_link[p] = heap_link[h];
		end else begin
			heap_link[p] = h;
		end
		rover_idx = p;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch on %s at cycle %0d: got %0d, expected %0d", what, cycle_count, got, want);
		fail_count++;
	endtask

	// result channel: random stall, every accepted beat checked against the oldest grant
	always @(posedge clk) begin
		grant_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_grants.size() == 0) begin
				report_mismatch("unexpected result beat, status", status, -1);
			end else begin
				want = pending_grants.pop_front();
				if (status !== want.st)
					report_mismatch("status", status, want.st);
				if (granted_address !== want.addr)
					report_mismatch("granted_address", granted_address, want.addr);
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic send_request(input mode_t m, input logic [REQ_W-1:0] bytes,
			input logic [ADDR_W-1:0] addr, output grant_result_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		mode          <= m;
		request_bytes <= bytes;
		block_address <= addr;
		do @(posedge clk); while (in_stall);
		if (m == MODE_ALLOC)
			r = predict_alloc(bytes);
		else
			r = predict_free(addr);
		pending_grants.push_back(r);
	endtask

	task automatic alloc_req(input int unsigned bytes, output logic [ADDR_W-1:0] got);
		grant_result_t r;
		send_request(MODE_ALLOC, REQ_W'(bytes), ADDR_W'($urandom), r);
		got = r.addr;
	endtask

	task automatic free_req(input int unsigned addr);
		grant_result_t r;
		send_request(MODE_FREE, REQ_W'($urandom), ADDR_W'(addr), r);
	endtask

	task automatic set_idling(input int idle, input int stall);
		send_idle_pct = idle;
		stall_pct     = stall;
	endtask

	// oversized request, exact fit of the whole heap, exhaustion and recovery
	task automatic test_whole_heap();
		logic [ADDR_W-1:0] a;
		logic [ADDR_W-1:0] dummy;
		alloc_req(65535, dummy);
		alloc_req(65520, a);
		alloc_req(0, dummy);
		alloc_req(65535, dummy);
		free_req(a);
	endtask

	task automatic test_ignored_frees();
		free_req(0);
		free_req(1);
		free_req(HEAP_UNITS + 2);
		free_req(2 ** ADDR_W - 1);
	endtask

	// tail splits, then frees with no neighbour, both neighbours and one neighbour free
	task automatic test_split_and_merge();
		logic [ADDR_W-1:0] a, b, c, d, e, w;
		alloc_req(0, a);
		alloc_req(1, b);
		alloc_req(16, c);
		alloc_req(17, d);
		alloc_req(4000, e);
		free_req(b);
		free_req(d);
		free_req(c);
		free_req(a);
		free_req(e);
		alloc_req(65520, w);
		free_req(w);
	endtask

	task automatic test_random_traffic(input int n, input int idle, input int stall);
		logic [ADDR_W-1:0] got;
		int sel;
		int idx;
		int unsigned bytes;
		set_idling(idle, stall);
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 5) begin
				case ($urandom_range(2))
					0: free_req($urandom_range(1));
					1: free_req($urandom_range(HEAP_UNITS + 2, 2 ** ADDR_W - 1));
					default: alloc_req($urandom_range(65521, 65535), got);
				endcase
			end else if (live_blocks.size() == 0 ||
					(live_blocks.size() < LIVE_CAP && $urandom_range(99) < 55)) begin
				sel = $urandom_range(99);
				if (sel < 70)
					bytes = $urandom_range(255);
				else if (sel < 95)
					bytes = $urandom_range(256, 4095);
				else
					bytes = $urandom_range(4096, 65535);
				alloc_req(bytes, got);
				if (got != 0)
					live_blocks.push_back(got);
			end else begin
				idx = $urandom_range(live_blocks.size() - 1);
				free_req(live_blocks[idx]);
				live_blocks.delete(idx);
			end
		end
	endtask

	// repeated and stray frees inside the heap; the list may be corrupted from here on
	task automatic test_unchecked_frees();
		logic [ADDR_W-1:0] got;
		set_idling(6, 6);
		alloc_req(40, got);
		free_req(got);
		free_req(got);
		if (live_blocks.size() != 0) begin
			free_req(live_blocks[0]);
			free_req(live_blocks[0]);
		end
		free_req(HEAP_UNITS + 1);
		for (int i = 0; i < 16; i++) begin
			if ($urandom_range(1))
				alloc_req($urandom_range(1023), got);
			else
				free_req($urandom_range(2, HEAP_UNITS + 1));
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		mode          <= MODE_ALLOC;
		request_bytes <= '0;
		block_address <= '0;
		out_stall     <= 1'b0;
		fail_count    = 0;
		cycle_count   = 0;
		heap_reset();
		set_idling(0, 0);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		test_whole_heap();
		test_ignored_frees();
		test_split_and_merge();
		test_random_traffic(240, 0, 0);
		test_random_traffic(240, 60, 0);
		test_random_traffic(240, 0, 60);
		test_random_traffic(240, 6, 6);
		test_unchecked_frees();
		in_valid <= 1'b0;

		while (pending_grants.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
